// ===== hdl/integer_hash_set_defines.svh =====
// Assertion macros used by hdl/ihs_core.sv.
`ifndef INTEGER_HASH_SET_DEFINES_SVH
`define INTEGER_HASH_SET_DEFINES_SVH

// Checked only while the block is out of reset.
`define IHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IHS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ihs_pkg.sv =====
`timescale 1ns / 1ps
package ihs_pkg;

	localparam int CAPACITY  = 64;
	localparam int BUCKETS   = 16;
	localparam int KEY_W     = 32;
	localparam int CNT_OUT_W = 7;
	localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int HEADS     = 1 << BKT_W;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_DEL   = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef struct packed {
		logic              vld;
		logic [SLOT_W-1:0] ptr;
	} link_t;

	typedef struct packed {
		link_t            lnk;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic                 was_member;
		logic [CNT_OUT_W-1:0] member_count;
		logic                 rejected_full;
	} result_t;

endpackage

// ===== hdl/ihs_core.sv =====
`timescale 1ns / 1ps
`include "integer_hash_set_defines.svh"
module ihs_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  ihs_pkg::action_t        in_action,
	input  logic [ihs_pkg::KEY_W-1:0] in_key,
	output logic                    res_valid,
	input  logic                    res_ready,
	output ihs_pkg::result_t        res
);
	import ihs_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_WALK    = 6'b000010,
		ST_RESOLVE = 6'b000100,
		ST_FREE    = 6'b001000,
		ST_POP     = 6'b010000,
		ST_RESP    = 6'b100000
	} state_t;

	state_t            state_q;
	action_t           act_q;
	logic [KEY_W-1:0]  key_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [SLOT_W-1:0] cur_q;
	logic [SLOT_W-1:0] prev_q;
	logic              prev_vld_q;
	logic [KEY_W-1:0]  prev_key_q;
	logic              found_q;
	logic [SLOT_W-1:0] fslot_q;
	link_t             flink_q;
	link_t             free_q;
	logic [CNT_W-1:0]  wm_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              was_q;
	logic              rej_q;
	logic              head_vld_q [HEADS];
	logic [SLOT_W-1:0] head_ptr_q [HEADS];

	entry_t            entry_mem [CAPACITY];
	entry_t            rd_q;
	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	entry_t            wr_data;

	logic [BKT_W-1:0]  bkt_in;
	link_t             head_lnk;
	logic              is_full;
	logic              wm_room;

	assign bkt_in   = in_key[BKT_W-1:0];
	assign head_lnk = '{vld: head_vld_q[bkt_q], ptr: head_ptr_q[bkt_q]};
	assign is_full  = (cnt_q == CNT_W'(CAPACITY));
	assign wm_room  = (wm_q < CNT_W'(CAPACITY));

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res.was_member    = was_q;
	assign res.member_count  = CNT_OUT_W'(cnt_q);
	assign res.rejected_full = rej_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '{lnk: head_lnk, key: key_q};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_action != ACT_CLEAR && head_vld_q[bkt_in]) begin
					rd_en   = 1'b1;
					rd_addr = head_ptr_q[bkt_in];
				end
			end
			ST_WALK: begin
				if (rd_q.key != key_q && rd_q.lnk.vld) begin
					rd_en   = 1'b1;
					rd_addr = rd_q.lnk.ptr;
				end
			end
			ST_RESOLVE: begin
				if (act_q == ACT_ADD && !found_q && !is_full) begin
					if (wm_room) begin
						wr_en   = 1'b1;
						wr_addr = wm_q[SLOT_W-1:0];
					end else begin
						rd_en   = 1'b1;
						rd_addr = free_q.ptr;
					end
				end else if (act_q == ACT_DEL && found_q && prev_vld_q) begin
					wr_en   = 1'b1;
					wr_addr = prev_q;
					wr_data = '{lnk: flink_q, key: prev_key_q};
				end
			end
			ST_FREE: begin
				wr_en   = 1'b1;
				wr_addr = fslot_q;
				wr_data = '{lnk: free_q, key: key_q};
			end
			ST_POP: begin
				wr_en   = 1'b1;
				wr_addr = free_q.ptr;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= entry_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			act_q <= in_action;
			key_q <= in_key;
			bkt_q <= bkt_in;
			cur_q <= head_ptr_q[bkt_in];
		end else if (state_q == ST_WALK && rd_q.key != key_q && rd_q.lnk.vld) begin
			prev_q     <= cur_q;
			prev_key_q <= rd_q.key;
			cur_q      <= rd_q.lnk.ptr;
		end
		if (state_q == ST_WALK && rd_q.key == key_q) begin
			fslot_q <= cur_q;
			flink_q <= rd_q.lnk;
		end
		if (state_q == ST_POP) begin
			head_ptr_q[bkt_q] <= free_q.ptr;
		end else if (state_q == ST_RESOLVE) begin
			if (act_q == ACT_ADD && !found_q && !is_full && wm_room) begin
				head_ptr_q[bkt_q] <= wm_q[SLOT_W-1:0];
			end else if (act_q == ACT_DEL && found_q && !prev_vld_q) begin
				head_ptr_q[bkt_q] <= flink_q.ptr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prev_vld_q <= 1'b0;
			found_q    <= 1'b0;
			free_q     <= '0;
			wm_q       <= '0;
			cnt_q      <= '0;
			was_q      <= 1'b0;
			rej_q      <= 1'b0;
			for (int i = 0; i < HEADS; i++) begin
				head_vld_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prev_vld_q <= 1'b0;
						found_q    <= 1'b0;
						if (in_action == ACT_CLEAR) begin
							for (int i = 0; i < HEADS; i++) begin
								head_vld_q[i] <= 1'b0;
							end
							free_q  <= '0;
							wm_q    <= '0;
							cnt_q   <= '0;
							was_q   <= 1'b0;
							rej_q   <= 1'b0;
							state_q <= ST_RESP;
						end else if (head_vld_q[bkt_in]) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_RESOLVE;
						end
					end
				end
				ST_WALK: begin
					if (rd_q.key == key_q) begin
						found_q <= 1'b1;
						state_q <= ST_RESOLVE;
					end else if (rd_q.lnk.vld) begin
						prev_vld_q <= 1'b1;
					end else begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					was_q   <= found_q;
					rej_q   <= 1'b0;
					state_q <= ST_RESP;
					unique case (act_q)
						ACT_ADD: begin
							if (found_q) begin
							end else if (is_full) begin
								rej_q <= 1'b1;
							end else if (wm_room) begin
								head_vld_q[bkt_q] <= 1'b1;
								wm_q  <= wm_q + CNT_W'(1);
								cnt_q <= cnt_q + CNT_W'(1);
							end else begin
								state_q <= ST_POP;
							end
						end
						ACT_DEL: begin
							if (found_q) begin
								if (!prev_vld_q) begin
									head_vld_q[bkt_q] <= flink_q.vld;
								end
								cnt_q   <= cnt_q - CNT_W'(1);
								state_q <= ST_FREE;
							end
						end
						ACT_QUERY, ACT_CLEAR: begin
						end
						default: begin
						end
					endcase
				end
				ST_FREE: begin
					free_q  <= '{vld: 1'b1, ptr: fslot_q};
					state_q <= ST_RESP;
				end
				ST_POP: begin
					free_q            <= rd_q.lnk;
					head_vld_q[bkt_q] <= 1'b1;
					cnt_q             <= cnt_q + CNT_W'(1);
					state_q           <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`IHS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "member count above capacity")
	`IHS_ASSERT(a_pop_nonempty, state_q == ST_POP |-> free_q.vld, "allocation from an empty free list")
	`IHS_ASSERT(a_reject_full, res_valid && res.rejected_full |-> is_full && !res.was_member, "add rejected while not full")
	`IHS_ASSERT(a_clear_empties, state_q == ST_IDLE && in_valid && in_action == ACT_CLEAR |=> cnt_q == '0 && wm_q == '0 && !free_q.vld, "clear left members behind")
	`IHS_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> state_q == ST_IDLE && cnt_q == '0, "control state not cleared by reset")

endmodule

// ===== hdl/integer_hash_set.sv =====
`timescale 1ns / 1ps
// Sequence: a clear goes from idle straight to the response state; any other action walks the
// key's bucket chain, resolves, then for a delete that hits or an add that reuses a freed slot
// passes through a free-list state before the response; results are held in an output register.
// Throughput: one word at a time in the core; its single entry memory is walked one link per cycle.
// Reset: asynchronous, clears the set, bucket heads and counters; the entry memory is not cleared.
module integer_hash_set (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // key
	input  logic [1:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // member_count, zero pad
	output logic [1:0]  m_tuser   // was_member, rejected_full
);
	import ihs_pkg::*;

	logic    res_valid;
	logic    res_ready;
	result_t res;
	logic    out_vld_q;
	result_t out_q;

	assign res_ready = !out_vld_q || m_tready;

	ihs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (action_t'(s_tuser)),
		.in_key    (s_tdata[KEY_W-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_q.member_count};
	assign m_tuser  = {out_q.rejected_full, out_q.was_member};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import ihs_pkg::*;

	localparam int CYCLE_LIMIT = 1200000;
	localparam int RANDOM_WORDS = 1350;

	typedef struct packed {
		action_t     act;
		logic [31:0] key;
		logic        typed;
		result_t     res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;

	logic [31:0] kept_key [CAPACITY];
	bit          kept_vld [CAPACITY];
	int          kept_cnt = 0;
	result_t     replies_due [$];
	int          fail_count = 0;
	int          cycles = 0;
	int          random_sent = 0;
	int          hold_req = 0;
	bit          tx_quiet = 0;
	bit          rx_quiet = 0;

	row_t script [0:22] = '{
		'{ACT_QUERY, 32'h0000_0000, 1'b1, '{1'b0, 7'd0, 1'b0}},
		'{ACT_ADD,   32'h0000_0000, 1'b1, '{1'b0, 7'd1, 1'b0}},
		'{ACT_ADD,   32'h0000_0000, 1'b1, '{1'b1, 7'd1, 1'b0}},
		'{ACT_ADD,   32'hFFFF_FFFF, 1'b1, '{1'b0, 7'd2, 1'b0}},
		'{ACT_QUERY, 32'hFFFF_FFFF, 1'b1, '{1'b1, 7'd2, 1'b0}},
		'{ACT_ADD,   32'h0000_0010, 1'b0, '0},
		'{ACT_ADD,   32'h8000_0000, 1'b0, '0},
		'{ACT_DEL,   32'h0000_0020, 1'b0, '0},
		'{ACT_DEL,   32'h0000_0010, 1'b0, '0},
		'{ACT_QUERY, 32'h0000_0010, 1'b0, '0},
		'{ACT_ADD,   32'h0000_0030, 1'b0, '0},
		'{ACT_QUERY, 32'h0000_0000, 1'b0, '0},
		'{ACT_DEL,   32'hFFFF_FFFF, 1'b0, '0},
		'{ACT_DEL,   32'hFFFF_FFFF, 1'b0, '0},
		'{ACT_CLEAR, 32'hFFFF_FFFF, 1'b1, '{1'b0, 7'd0, 1'b0}},
		'{ACT_QUERY, 32'h0000_0000, 1'b1, '{1'b0, 7'd0, 1'b0}},
		'{ACT_DEL,   32'h0000_0000, 1'b1, '{1'b0, 7'd0, 1'b0}},
		'{ACT_CLEAR, 32'h0000_0000, 1'b1, '{1'b0, 7'd0, 1'b0}},
		'{ACT_ADD,   32'h7FFF_FFFF, 1'b1, '{1'b0, 7'd1, 1'b0}},
		'{ACT_ADD,   32'h5555_5555, 1'b0, '0},
		'{ACT_ADD,   32'hAAAA_AAAA, 1'b0, '0},
		'{ACT_QUERY, 32'hAAAA_AAAA, 1'b0, '0},
		'{ACT_CLEAR, 32'h1234_5678, 1'b1, '{1'b0, 7'd0, 1'b0}}
	};

	integer_hash_set i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic result_t set_step(action_t act, logic [31:0] key);
		result_t r;
		int hit;
		int free;
		r = '0;
		hit = -1;
		free = -1;
		if (act == ACT_CLEAR) begin
			for (int i = 0; i < CAPACITY; i++) kept_vld[i] = 1'b0;
			kept_cnt = 0;
		end else begin
			for (int i = 0; i < CAPACITY; i++)
				if (hit < 0 && kept_vld[i] && kept_key[i] == key) hit = i;
			r.was_member = (hit >= 0);
			if (act == ACT_ADD && hit < 0) begin
				if (kept_cnt < CAPACITY)
					for (int i = 0; i < CAPACITY; i++)
						if (free < 0 && !kept_vld[i]) free = i;
				if (free < 0) begin
					r.rejected_full = 1'b1;
				end else begin
					kept_key[free] = key;
					kept_vld[free] = 1'b1;
					kept_cnt++;
				end
			end else if (act == ACT_DEL && hit >= 0) begin
				kept_vld[hit] = 1'b0;
				kept_cnt--;
			end
		end
		r.member_count = kept_cnt[CNT_OUT_W-1:0];
		return r;
	endfunction

	// Keys mostly come from a pool crowded into four buckets, so chains grow long.
	function automatic logic [31:0] pick_key();
		logic [31:0] k;
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			k = $urandom;
		end else if (r < 20) begin
			case ($urandom_range(0, 3))
				0: k = 32'h0000_0000;
				1: k = 32'hFFFF_FFFF;
				2: k = 32'h8000_0000;
				default: k = 32'h7FFF_FFFF;
			endcase
		end else begin
			k = ($urandom_range(0, 23) << 4) | $urandom_range(0, 3);
			if ($urandom_range(0, 1) == 1) k[31:16] = 16'hFFFF;
		end
		return k;
	endfunction

	function automatic logic [31:0] member_key();
		int start;
		int idx;
		start = $urandom_range(0, CAPACITY - 1);
		for (int j = 0; j < CAPACITY; j++) begin
			idx = (start + j) % CAPACITY;
			if (kept_vld[idx]) return kept_key[idx];
		end
		return pick_key();
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	task automatic send_word(action_t act, logic [31:0] key, logic typed, result_t want);
		result_t got_pred;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= key;
		do @(posedge clk); while (!s_tready);
		got_pred = set_step(act, key);
		replies_due.push_back(typed ? want : got_pred);
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(action_t act, logic [31:0] key);
		send_word(act, key, 1'b0, '0);
		random_sent++;
	endtask

	task automatic run_mixed(int n, int add_w, int del_w, int qry_w);
		action_t act;
		logic [31:0] key;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < add_w) act = ACT_ADD;
			else if (r < add_w + del_w) act = ACT_DEL;
			else if (r < add_w + del_w + qry_w) act = ACT_QUERY;
			else act = ACT_CLEAR;
			key = (kept_cnt > 0 && $urandom_range(0, 2) == 0) ? member_key() : pick_key();
			send_random(act, key);
		end
	endtask

	// Runs the set up to capacity and beyond, works on it while full, then frees slots.
	task automatic run_fill();
		send_random(ACT_CLEAR, $urandom);
		for (int i = 0; i < CAPACITY + 8; i++)
			send_random(ACT_ADD, ($urandom_range(0, 4) == 0) ? pick_key() : $urandom);
		run_mixed(30, 45, 5, 50);
		run_mixed(20, 30, 50, 20);
	endtask

	task automatic run_drain();
		while (kept_cnt > 0) begin
			if ($urandom_range(0, 3) == 0) send_random(ACT_QUERY, pick_key());
			send_random(ACT_DEL, member_key());
		end
		send_random(ACT_QUERY, pick_key());
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (rx_quiet || $urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
					: $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.was_member    = m_tuser[0];
			got.rejected_full = m_tuser[1];
			got.member_count  = m_tdata[CNT_OUT_W-1:0];
			if (replies_due.size() == 0) begin
				$display("%0t: word with none pending: was_member %0d count %0d rejected %0d",
					$time, got.was_member, got.member_count, got.rejected_full);
				fail_count++;
			end else begin
				want = replies_due.pop_front();
				if (got.was_member !== want.was_member) begin
					$display("%0t: was_member expected %0d got %0d",
						$time, want.was_member, got.was_member);
					fail_count++;
				end
				if (got.member_count !== want.member_count) begin
					$display("%0t: member_count expected %0d got %0d",
						$time, want.member_count, got.member_count);
					fail_count++;
				end
				if (got.rejected_full !== want.rejected_full) begin
					$display("%0t: rejected_full expected %0d got %0d",
						$time, want.rejected_full, got.rejected_full);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		int ph;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_ADD;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_word(script[i].act, script[i].key, script[i].typed, script[i].res);

		ph = 0;
		while (random_sent < RANDOM_WORDS) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (ph == 1) hold_req = 400;
			case (ph % 4)
				0: run_mixed(80, 45, 20, 33);
				1: run_fill();
				2: run_mixed(60, 25, 35, 38);
				default: run_drain();
			endcase
			if (ph == 2 || $urandom_range(0, 2) == 0) begin
				s_tvalid <= 1'b0;
				while (replies_due.size() != 0) @(posedge clk);
			end
			ph++;
		end
		s_tvalid <= 1'b0;

		while (replies_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ihs_pkg.sv
hdl/ihs_core.sv
hdl/integer_hash_set.sv
bench/tb.sv
